FILE: sv/block_bitmap_allocator_defines.svh
// ----------------------------------------------------------------------------
// Block bitmap allocator assertion macros
// Shorthands for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Shared types, codes and constants of the allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int ADDR_W         = 12;
    localparam int LIMIT_W        = 13;
    localparam int MARK_W         = 13;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_NOT_USED = 2'd3
    } alloc_status_t;

    typedef struct packed
    {
        cmd_t              cmd;
        logic [ADDR_W-1:0] block_addr;
    } req_t;

    typedef struct packed
    {
        alloc_status_t     status;
        logic [ADDR_W-1:0] granted_block;
        logic              extended;
        logic [MARK_W-1:0] used_mark;
    } rsp_t;

    typedef enum logic [1:0]
    {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    // controller -> datapath
    typedef struct packed
    {
        logic clear_step;
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic clear_last;
    } dp_stat_t;

endpackage

FILE: sv/block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator
// Allocates blocks from a FIFO of freed holes, then from a high-water mark;
// frees blocks after a range and used-bit check.
// ----------------------------------------------------------------------------
// Each transaction passes through S_IDLE, which captures the request and reads
// the used-bit and hole memories (registered reads), and S_EXEC, which computes
// the result, writes both memories back and loads the output register. A
// stalled output holds S_EXEC until the previous result is taken. After reset
// the used-bit memory is cleared one entry per cycle over all MAX_BLOCKS entries,
// with req_stall high; limit writes are taken during that pass.

`include "block_bitmap_allocator_defines.svh"

module block_bitmap_allocator
#(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  bba_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output bba_pkg::rsp_t               rsp,
    input  logic                        limit_we,
    input  logic [bba_pkg::LIMIT_W-1:0] limit_data
);
    import bba_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    bba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (ctrl_cmd),
        .stat      (dp_stat)
    );

    bba_datapath
    #(
        .MAX_BLOCKS (MAX_BLOCKS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctrl_cmd),
        .stat       (dp_stat),
        .req        (req),
        .limit_we   (limit_we),
        .limit_data (limit_data),
        .rsp        (rsp)
    );

    // one transaction in flight at a time
    `BBA_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall, "second request accepted while busy")
    // no request taken during the bitmap clearing pass
    `BBA_ASSERT_SAME(a_no_accept_clear, ctrl_cmd.clear_step, req_stall && !ctrl_cmd.commit, "accept or commit during clear")
    // an extension hands out the block just below the new mark
    `BBA_ASSERT_SAME(a_ext_grant, rsp_valid && rsp.extended, rsp.status == STAT_OK && rsp.granted_block == ADDR_W'(rsp.used_mark - 13'd1), "extension grant mismatch")

endmodule

FILE: sv/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator controller
// Sequences the bitmap clear, request capture and commit of each transaction.
// ----------------------------------------------------------------------------
module bba_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output bba_pkg::ctrl_cmd_t  cmd,
    input  bba_pkg::dp_stat_t   stat
);
    import bba_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd.clear_step = 1'b0;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        req_stall      = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            S_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            S_EXEC:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: sv/bba_datapath.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator datapath
// Used-bit memory, hole FIFO memory, pointers, high-water mark and result.
// ----------------------------------------------------------------------------
module bba_datapath
#(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  bba_pkg::ctrl_cmd_t          cmd,
    output bba_pkg::dp_stat_t           stat,
    input  bba_pkg::req_t               req,
    input  logic                        limit_we,
    input  logic [bba_pkg::LIMIT_W-1:0] limit_data,
    output bba_pkg::rsp_t               rsp
);
    import bba_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

    logic              used_mem [MAX_BLOCKS];
    logic [IDX_W-1:0]  hole_mem [MAX_BLOCKS];

    logic [LIMIT_W-1:0] limit_reg;
    logic [IDX_W-1:0]   clr_idx_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   head_next;
    logic [IDX_W-1:0]   tail_reg;
    logic [IDX_W-1:0]   tail_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   mark_reg;
    logic [CNT_W-1:0]   mark_next;
    cmd_t               cmd_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               used_rd_reg;
    logic [IDX_W-1:0]   hole_rd_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic [CMP_W-1:0]   lim_eff;
    logic [IDX_W-1:0]   addr_idx;
    logic               bit_we;
    logic [IDX_W-1:0]   bit_waddr;
    logic               bit_wdata;
    logic               set_we;
    logic [IDX_W-1:0]   set_addr;
    logic               set_val;
    logic               hole_push;

    assign lim_eff = (CMP_W'(limit_reg) > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS)
                                                              : CMP_W'(limit_reg);
    assign addr_idx = IDX_W'(addr_reg);
    assign stat.clear_last = cmd.clear_step && (clr_idx_reg == LAST_IDX);

    // Result and state update for the captured transaction
    always_comb
    begin
        rsp_next.status        = STAT_OK;
        rsp_next.granted_block = '0;
        rsp_next.extended      = 1'b0;
        head_next              = head_reg;
        tail_next              = tail_reg;
        count_next             = count_reg;
        mark_next              = mark_reg;
        set_we                 = 1'b0;
        set_addr               = addr_idx;
        set_val                = 1'b0;
        hole_push              = 1'b0;
        unique case (cmd_reg)
            CMD_ALLOC:
            begin
                if (count_reg != '0)
                begin
                    // oldest hole first, even if it now sits above the limit
                    rsp_next.granted_block = ADDR_W'(hole_rd_reg);
                    head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    set_we     = 1'b1;
                    set_addr   = hole_rd_reg;
                    set_val    = 1'b1;
                end
                else if (CMP_W'(mark_reg) >= lim_eff)
                begin
                    rsp_next.status = STAT_FULL;
                end
                else
                begin
                    rsp_next.granted_block = ADDR_W'(mark_reg);
                    rsp_next.extended      = 1'b1;
                    mark_next = mark_reg + 1'b1;
                    set_we    = 1'b1;
                    set_addr  = IDX_W'(mark_reg);
                    set_val   = 1'b1;
                end
            end
            CMD_FREE:
            begin
                if (CMP_W'(addr_reg) >= lim_eff)
                begin
                    rsp_next.status = STAT_RANGE;
                end
                else if (!used_rd_reg)
                begin
                    rsp_next.status = STAT_NOT_USED;
                end
                else
                begin
                    set_we = 1'b1;
                    if (count_reg < CNT_W'(MAX_BLOCKS))
                    begin
                        hole_push  = 1'b1;
                        tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                rsp_next.status = STAT_OK;
            end
        endcase
        rsp_next.used_mark = MARK_W'(mark_next);
    end

    // Single bitmap write port: clearing pass or transaction commit
    always_comb
    begin
        if (cmd.clear_step)
        begin
            bit_we    = 1'b1;
            bit_waddr = clr_idx_reg;
            bit_wdata = 1'b0;
        end
        else
        begin
            bit_we    = cmd.commit && set_we;
            bit_waddr = set_addr;
            bit_wdata = set_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bit_we)
        begin
            used_mem[bit_waddr] <= bit_wdata;
        end
        if (cmd.capture)
        begin
            used_rd_reg <= used_mem[IDX_W'(req.block_addr)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && hole_push)
        begin
            hole_mem[tail_reg] <= addr_idx;
        end
        if (cmd.capture)
        begin
            hole_rd_reg <= hole_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= req.cmd;
            addr_reg <= req.block_addr;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            clr_idx_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            mark_reg    <= '0;
        end
        else
        begin
            if (limit_we)
            begin
                limit_reg <= limit_data;
            end
            if (cmd.clear_step)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                mark_reg  <= mark_next;
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: tb/sv/bba_checker.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator checker
// Watches the request, response and limit ports, keeps its own copy of the
// used map, hole FIFO and high-water mark, and compares every response
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module bba_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_stall,
    input  bba_pkg::req_t               req,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  bba_pkg::rsp_t               rsp,
    input  logic                        limit_we,
    input  logic [bba_pkg::LIMIT_W-1:0] limit_data,
    output int                          mismatches,
    output int                          owed
);
    import bba_pkg::*;

    logic                used_map [MAX_BLOCKS_DEF];
    logic [ADDR_W-1:0]   hole_fifo [$];
    logic [MARK_W-1:0]   mark;
    logic [LIMIT_W-1:0]  limit_reg;
    rsp_t                owed_rsp [$];
    rsp_t                want;

    // Applies one request to the shadow state and returns the response it owes.
    function automatic rsp_t serve_request(req_t r);
        rsp_t o;
        int   lim;
        o = '0;
        o.status = STAT_OK;
        lim = (limit_reg > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(limit_reg);
        if (r.cmd == CMD_ALLOC)
        begin
            // holes first, even one that now sits above a lowered limit
            if (hole_fifo.size() > 0)
            begin
                o.granted_block = hole_fifo.pop_front();
                used_map[o.granted_block] = 1'b1;
            end
            else if (int'(mark) >= lim)
            begin
                o.status = STAT_FULL;
            end
            else
            begin
                used_map[mark[ADDR_W-1:0]] = 1'b1;
                o.granted_block = mark[ADDR_W-1:0];
                o.extended = 1'b1;
                mark = mark + 1'b1;
            end
        end
        else
        begin
            if (int'(r.block_addr) >= lim)
            begin
                o.status = STAT_RANGE;
            end
            else if (!used_map[r.block_addr])
            begin
                o.status = STAT_NOT_USED;
            end
            else
            begin
                used_map[r.block_addr] = 1'b0;
                hole_fifo.push_back(r.block_addr);
            end
        end
        o.used_mark = mark;
        return o;
    endfunction

    task automatic compare_field(string name, logic [15:0] w, logic [15:0] g);
        if (g !== w)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, w, g);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BLOCKS_DEF; i++)
                used_map[i] = 1'b0;
            hole_fifo.delete();
            owed_rsp.delete();
            mark       = '0;
            limit_reg  = LIMIT_RESET;
            mismatches = 0;
            owed       = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, got %h", $time, rsp);
                    mismatches++;
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    compare_field("status", 16'(want.status), 16'(rsp.status));
                    compare_field("granted_block", 16'(want.granted_block),
                                  16'(rsp.granted_block));
                    compare_field("extended", 16'(want.extended), 16'(rsp.extended));
                    compare_field("used_mark", 16'(want.used_mark), 16'(rsp.used_mark));
                end
            end
            if (limit_we)
                limit_reg = limit_data;
            if (req_valid && !req_stall)
                owed_rsp.push_back(serve_request(req));
            owed = owed_rsp.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator testbench
// Drives directed and random allocate/free traffic through several block
// limits with random idling on both channels; a checker beside the block
// predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
    import bba_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    req_t                req;
    logic                rsp_valid;
    logic                rsp_stall;
    rsp_t                rsp;
    logic                limit_we;
    logic [LIMIT_W-1:0]  limit_data;
    int                  mismatches;
    int                  owed;

    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  hold_left;

    block_bitmap_allocator uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .limit_we   (limit_we),
        .limit_data (limit_data)
    );

    bba_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .limit_we   (limit_we),
        .limit_data (limit_data),
        .mismatches (mismatches),
        .owed       (owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("FAIL block_bitmap_allocator");
        $finish;
    end

    // Response side: random stalls, or a long hold-off when one is requested.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic send_req(cmd_t c, logic [ADDR_W-1:0] a);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= '{cmd: c, block_addr: a};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        wait (owed == 0);
    endtask

    task automatic set_limit(logic [LIMIT_W-1:0] v);
        drain();
        repeat (4) @(negedge clk);
        limit_we <= 1'b1;
        limit_data <= v;
        @(negedge clk);
        limit_we <= 1'b0;
    endtask

    // Mostly allocates and frees up to lim + 3; some frees at any address.
    task automatic random_traffic(int n, int lim, int pause_at);
        int roll;
        int hi;
        hi = (lim + 3 > 4095) ? 4095 : lim + 3;
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                drain();
            roll = $urandom_range(99);
            if (roll < 55)
                send_req(CMD_ALLOC, ADDR_W'($urandom));
            else if (roll < 90)
                send_req(CMD_FREE, ADDR_W'($urandom_range(0, hi)));
            else
                send_req(CMD_FREE, ADDR_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        limit_we = 1'b0;
        limit_data = '0;
        hold_left = 0;
        send_idle_pct = 28;
        recv_idle_pct = 74;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // zero limit: nothing fits
        set_limit(13'd0);
        send_req(CMD_ALLOC, 12'hFFF);
        send_req(CMD_FREE, 12'h000);
        send_req(CMD_FREE, 12'hFFF);

        // limit above the store size saturates
        set_limit(13'h1FFF);
        send_req(CMD_FREE, 12'hFFF);
        send_req(CMD_ALLOC, 12'hFFF);
        send_req(CMD_ALLOC, 12'h000);
        send_req(CMD_ALLOC, 12'h555);
        send_req(CMD_FREE, 12'd1);
        send_req(CMD_FREE, 12'd1);
        send_req(CMD_FREE, 12'd0);
        send_req(CMD_ALLOC, 12'hAAA);
        send_req(CMD_ALLOC, 12'h000);
        send_req(CMD_ALLOC, 12'h000);

        // mark reaches the limit
        set_limit(13'd4);
        send_req(CMD_ALLOC, 12'h000);
        send_req(CMD_FREE, 12'd2);
        send_req(CMD_FREE, 12'd3);

        // lowered below queued holes and below the mark
        set_limit(13'd1);
        send_req(CMD_ALLOC, 12'h000);
        send_req(CMD_FREE, 12'd3);
        send_req(CMD_ALLOC, 12'h000);
        send_req(CMD_ALLOC, 12'h000);
        send_req(CMD_FREE, 12'd0);
        send_req(CMD_ALLOC, 12'h000);

        set_limit(13'd64);
        random_traffic(150, 64, -1);

        send_idle_pct = 74;
        recv_idle_pct = 28;
        set_limit(13'd200);
        random_traffic(150, 200, -1);

        // no idling; long receiver hold-off fills the block, then a full pause
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limit(13'd20);
        hold_left = 150;
        random_traffic(150, 20, 75);

        set_limit(LIMIT_RESET);
        random_traffic(20, 4096, -1);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && owed == 0)
            $display("PASS block_bitmap_allocator");
        else
            $display("FAIL block_bitmap_allocator");
        $finish;
    end

endmodule
